>>> design/gha_pkg.sv
// ----------------------------------------------------------------------------
// gha_pkg
// Shared types and codes for the generational handle allocator: operation
// codes, status codes and the sequencer state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package gha_pkg;

  // Request operation codes
  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CHECK  = 2'd2
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_NO_FREE    = 2'd1,
    STATUS_BAD_HANDLE = 2'd2
  } status_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_INIT,      // clearing pass after reset
    ST_IDLE,      // wait for a request
    ST_CR_RING,   // create: free ring data back, append to live list
    ST_CR_GEN,    // create: generation data back
    ST_HD_LOOK,   // handle: generation and live position back
    ST_HD_LIST,   // handle: live list entry back
    ST_RM_LAST,   // remove: last live entry back, swap and free
    ST_RESP       // hand the result to the output register
  } state_e;

endpackage

`default_nettype wire

>>> design/gha_ram.sv
// ----------------------------------------------------------------------------
// gha_ram
// Generic single-write, single-read synchronous RAM with a registered read
// port. Contents are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module gha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

>>> design/generational_handle_allocator_top.sv
// ----------------------------------------------------------------------------
// generational_handle_allocator_top
// Allocates generational handles (slot plus generation) from a FIFO ring of
// free slots, keeps a dense live list with swap-with-last removal, and
// checks handles for currency. State lives in four synchronous RAMs.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake               Payload
//  -------  ---  ----------------------  ----------------------------------
//  in       in   in_valid_i / in_stall_o  operation, handle_slot,
//                                         handle_generation
//  out      out  out_valid_o / out_stall_i status, out_slot, out_generation,
//                                         live_count
//
//  One request at a time. Create passes through ST_CR_RING and ST_CR_GEN,
//  check through ST_HD_LOOK and ST_HD_LIST, and remove through ST_RM_LAST
//  as well; a handle that fails its generation or position test, or a
//  request rejected up front, goes straight to ST_RESP. The next request
//  is taken only after ST_RESP has loaded the output register. Each step
//  waits on one registered read of the free ring, generation, live list
//  or live position RAM. After reset a clearing pass fills the free ring
//  and zeroes the generations; in_stall_o stays high during it.
//  A stalled output holds its result; the finished request waits in
//  ST_RESP until the output register frees, and no new request is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module generational_handle_allocator_top
  import gha_pkg::*;
#(
  parameter int SLOT_COUNT      = 1024,
  parameter int GENERATION_BITS = 31
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // request channel
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic [1:0]                           operation_i,
  input  wire logic [$clog2(SLOT_COUNT)-1:0]        handle_slot_i,
  input  wire logic [GENERATION_BITS-1:0]           handle_generation_i,
  // result channel
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic [1:0]                                status_o,
  output logic [$clog2(SLOT_COUNT)-1:0]             out_slot_o,
  output logic [GENERATION_BITS-1:0]                out_generation_o,
  output logic [$clog2(SLOT_COUNT+1)-1:0]           live_count_o
);

  localparam int SLOT_W  = $clog2(SLOT_COUNT);
  localparam int COUNT_W = $clog2(SLOT_COUNT + 1);
  localparam int GEN_W   = GENERATION_BITS;

  localparam logic [SLOT_W-1:0]  SLOT_MAX  = SLOT_W'(SLOT_COUNT - 1);
  localparam logic [SLOT_W:0]    SLOT_LIM  = (SLOT_W + 1)'(SLOT_COUNT);
  localparam logic [COUNT_W-1:0] COUNT_ALL = COUNT_W'(SLOT_COUNT);

  // Sequencer and bookkeeping registers
  state_e               state_q, state_d;
  logic [SLOT_W-1:0]    idx_q, idx_d;
  logic [1:0]           op_q, op_d;
  logic [SLOT_W-1:0]    slot_q, slot_d;
  logic [GEN_W-1:0]     hgen_q, hgen_d;
  logic [SLOT_W-1:0]    pos_q, pos_d;
  logic [SLOT_W-1:0]    cs_q, cs_d;
  logic [SLOT_W-1:0]    free_head_q, free_head_d;
  logic [SLOT_W-1:0]    free_tail_q, free_tail_d;
  logic [COUNT_W-1:0]   free_count_q, free_count_d;
  logic [COUNT_W-1:0]   live_total_q, live_total_d;

  // Pending result
  logic [1:0]           res_status_q, res_status_d;
  logic [SLOT_W-1:0]    res_slot_q, res_slot_d;
  logic [GEN_W-1:0]     res_gen_q, res_gen_d;

  // Output register
  logic                 out_valid_q, out_valid_d;
  logic [1:0]           out_status_q, out_status_d;
  logic [SLOT_W-1:0]    out_slot_q, out_slot_d;
  logic [GEN_W-1:0]     out_gen_q, out_gen_d;
  logic [COUNT_W-1:0]   out_count_q, out_count_d;

  // RAM ports
  logic                 ring_wr_en;
  logic [SLOT_W-1:0]    ring_wr_addr, ring_wr_data, ring_rd_addr, ring_rd_data;
  logic                 gen_wr_en;
  logic [SLOT_W-1:0]    gen_wr_addr, gen_rd_addr;
  logic [GEN_W-1:0]     gen_wr_data, gen_rd_data;
  logic                 list_wr_en;
  logic [SLOT_W-1:0]    list_wr_addr, list_wr_data, list_rd_addr, list_rd_data;
  logic                 pos_wr_en;
  logic [SLOT_W-1:0]    pos_wr_addr, pos_wr_data, pos_rd_addr, pos_rd_data;

  logic                 in_accept;
  logic [SLOT_W-1:0]    live_last;

  // Free ring: FIFO of free slot indexes
  gha_ram #(.WIDTH(SLOT_W), .DEPTH(SLOT_COUNT)) u_free_ring (
    .clk_i     (clk_i),
    .wr_en_i   (ring_wr_en),
    .wr_addr_i (ring_wr_addr),
    .wr_data_i (ring_wr_data),
    .rd_addr_i (ring_rd_addr),
    .rd_data_o (ring_rd_data)
  );

  // Per-slot generation
  gha_ram #(.WIDTH(GEN_W), .DEPTH(SLOT_COUNT)) u_slot_gen (
    .clk_i     (clk_i),
    .wr_en_i   (gen_wr_en),
    .wr_addr_i (gen_wr_addr),
    .wr_data_i (gen_wr_data),
    .rd_addr_i (gen_rd_addr),
    .rd_data_o (gen_rd_data)
  );

  // Dense live list
  gha_ram #(.WIDTH(SLOT_W), .DEPTH(SLOT_COUNT)) u_live_list (
    .clk_i     (clk_i),
    .wr_en_i   (list_wr_en),
    .wr_addr_i (list_wr_addr),
    .wr_data_i (list_wr_data),
    .rd_addr_i (list_rd_addr),
    .rd_data_o (list_rd_data)
  );

  // Position of each live slot within the live list
  gha_ram #(.WIDTH(SLOT_W), .DEPTH(SLOT_COUNT)) u_live_pos (
    .clk_i     (clk_i),
    .wr_en_i   (pos_wr_en),
    .wr_addr_i (pos_wr_addr),
    .wr_data_i (pos_wr_data),
    .rd_addr_i (pos_rd_addr),
    .rd_data_o (pos_rd_data)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign live_last  = SLOT_W'(live_total_q - COUNT_W'(1));

  // State and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_INIT;
      idx_q        <= '0;
      free_head_q  <= '0;
      free_tail_q  <= '0;
      free_count_q <= COUNT_ALL;
      live_total_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      free_head_q  <= free_head_d;
      free_tail_q  <= free_tail_d;
      free_count_q <= free_count_d;
      live_total_q <= live_total_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    slot_q       <= slot_d;
    hgen_q       <= hgen_d;
    pos_q        <= pos_d;
    cs_q         <= cs_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_gen_q    <= res_gen_d;
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
    out_gen_q    <= out_gen_d;
    out_count_q  <= out_count_d;
  end

  // Next state, RAM control and result
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    op_d         = op_q;
    slot_d       = slot_q;
    hgen_d       = hgen_q;
    pos_d        = pos_q;
    cs_d         = cs_q;
    free_head_d  = free_head_q;
    free_tail_d  = free_tail_q;
    free_count_d = free_count_q;
    live_total_d = live_total_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_gen_d    = res_gen_q;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_gen_d    = out_gen_q;
    out_count_d  = out_count_q;

    ring_wr_en   = 1'b0;
    ring_wr_addr = free_tail_q;
    ring_wr_data = slot_q;
    ring_rd_addr = free_head_q;
    gen_wr_en    = 1'b0;
    gen_wr_addr  = slot_q;
    gen_wr_data  = GEN_W'(hgen_q + GEN_W'(1));
    gen_rd_addr  = handle_slot_i;
    list_wr_en   = 1'b0;
    list_wr_addr = pos_q;
    list_wr_data = list_rd_data;
    list_rd_addr = pos_rd_data;
    pos_wr_en    = 1'b0;
    pos_wr_addr  = list_rd_data;
    pos_wr_data  = pos_q;
    pos_rd_addr  = handle_slot_i;

    // Drop the output once taken
    out_valid_d = out_valid_q && out_stall_i;

    case (state_q)
      // Fill the ring with every slot in order, zero all generations
      ST_INIT: begin
        ring_wr_en   = 1'b1;
        ring_wr_addr = idx_q;
        ring_wr_data = idx_q;
        gen_wr_en    = 1'b1;
        gen_wr_addr  = idx_q;
        gen_wr_data  = '0;
        idx_d        = idx_q + SLOT_W'(1);
        if (idx_q == SLOT_MAX) begin
          idx_d   = '0;
          state_d = ST_IDLE;
        end
      end

      // Take a request and start the first reads
      ST_IDLE: begin
        if (in_accept) begin
          op_d         = operation_i;
          slot_d       = handle_slot_i;
          hgen_d       = handle_generation_i;
          res_status_d = STATUS_BAD_HANDLE;
          res_slot_d   = handle_slot_i;
          res_gen_d    = handle_generation_i;
          state_d      = ST_RESP;
          case (operation_i)
            OP_CREATE: begin
              if (free_count_q == '0 || live_total_q >= COUNT_ALL) begin
                res_status_d = STATUS_NO_FREE;
                res_slot_d   = '0;
                res_gen_d    = '0;
              end else begin
                ring_rd_addr = free_head_q;
                state_d      = ST_CR_RING;
              end
            end
            OP_REMOVE, OP_CHECK: begin
              if ({1'b0, handle_slot_i} < SLOT_LIM) begin
                gen_rd_addr = handle_slot_i;
                pos_rd_addr = handle_slot_i;
                state_d     = ST_HD_LOOK;
              end
            end
            default: begin
              state_d = ST_RESP;
            end
          endcase
        end
      end

      // Pop the free slot, append it to the live list, fetch its generation
      ST_CR_RING: begin
        cs_d         = ring_rd_data;
        gen_rd_addr  = ring_rd_data;
        list_wr_en   = 1'b1;
        list_wr_addr = live_total_q[SLOT_W-1:0];
        list_wr_data = ring_rd_data;
        pos_wr_en    = 1'b1;
        pos_wr_addr  = ring_rd_data;
        pos_wr_data  = live_total_q[SLOT_W-1:0];
        free_head_d  = (free_head_q == SLOT_MAX) ? '0 : free_head_q + SLOT_W'(1);
        free_count_d = free_count_q - COUNT_W'(1);
        live_total_d = live_total_q + COUNT_W'(1);
        state_d      = ST_CR_GEN;
      end

      // Report the created handle
      ST_CR_GEN: begin
        res_status_d = STATUS_OK;
        res_slot_d   = cs_q;
        res_gen_d    = gen_rd_data;
        state_d      = ST_RESP;
      end

      // Match generation, range-check the live position, fetch the list entry
      ST_HD_LOOK: begin
        pos_d = pos_rd_data;
        if (gen_rd_data != hgen_q || {1'b0, pos_rd_data} >= live_total_q) begin
          state_d = ST_RESP;
        end else begin
          list_rd_addr = pos_rd_data;
          state_d      = ST_HD_LIST;
        end
      end

      // Confirm the slot sits in the live list
      ST_HD_LIST: begin
        if (list_rd_data != slot_q) begin
          state_d = ST_RESP;
        end else if (op_q == OP_CHECK) begin
          res_status_d = STATUS_OK;
          state_d      = ST_RESP;
        end else begin
          list_rd_addr = live_last;
          state_d      = ST_RM_LAST;
        end
      end

      // Move the last live entry into the hole, bump generation, free slot
      ST_RM_LAST: begin
        list_wr_en   = 1'b1;
        list_wr_addr = pos_q;
        list_wr_data = list_rd_data;
        pos_wr_en    = 1'b1;
        pos_wr_addr  = list_rd_data;
        pos_wr_data  = pos_q;
        live_total_d = live_total_q - COUNT_W'(1);
        gen_wr_en    = 1'b1;
        gen_wr_addr  = slot_q;
        gen_wr_data  = GEN_W'(hgen_q + GEN_W'(1));
        if (free_count_q < COUNT_ALL) begin
          ring_wr_en   = 1'b1;
          ring_wr_addr = free_tail_q;
          ring_wr_data = slot_q;
          free_tail_d  = (free_tail_q == SLOT_MAX) ? '0 : free_tail_q + SLOT_W'(1);
          free_count_d = free_count_q + COUNT_W'(1);
        end
        res_status_d = STATUS_OK;
        res_slot_d   = slot_q;
        res_gen_d    = GEN_W'(hgen_q + GEN_W'(1));
        state_d      = ST_RESP;
      end

      // Load the output register once it is free
      ST_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_slot_d   = res_slot_q;
          out_gen_d    = res_gen_q;
          out_count_d  = live_total_q;
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign out_slot_o       = out_slot_q;
  assign out_generation_o = out_gen_q;
  assign live_count_o     = out_count_q;

endmodule

`default_nettype wire
